>>> sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CPTD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define CPTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

>>> sv/cptd_pkg.sv
// Shared types and constants for the capacitive proximity and touch detector.
// No dependencies; imported by the step logic, the top level and the checker.
`default_nettype none

package cptd_pkg;

  localparam int SAMPLE_W = 18;
  localparam int TIME_W = 32;
  localparam int FRAC_W = 8;
  localparam int DELAY_W = 16;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W = 32;

  // Detector modes, as reported on the mode field.
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PROX  = 2'd1,
    MODE_TOUCH = 2'd2
  } mode_t;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_ADAPT_RATE    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RESEED_FRAC   = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PROX_FRAC     = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TOUCH_FRAC    = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_FRAC  = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM_DELAY = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PROX_TIMEOUT  = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_TOUCH_TIMEOUT = 4'd7;

  // Register values after reset.
  localparam logic [FRAC_W-1:0]  RST_ADAPT_RATE    = 8'd4;
  localparam logic [FRAC_W-1:0]  RST_RESEED_FRAC   = 8'd32;
  localparam logic [FRAC_W-1:0]  RST_PROX_FRAC     = 8'd32;
  localparam logic [FRAC_W-1:0]  RST_TOUCH_FRAC    = 8'd32;
  localparam logic [FRAC_W-1:0]  RST_RELEASE_FRAC  = 8'd8;
  localparam logic [DELAY_W-1:0] RST_CONFIRM_DELAY = 16'd20;
  localparam logic [TIME_W-1:0]  RST_PROX_TIMEOUT  = 32'd10000;
  localparam logic [TIME_W-1:0]  RST_TOUCH_TIMEOUT = 32'd10000;

  typedef struct packed {
    logic [FRAC_W-1:0]  adapt_rate;
    logic [FRAC_W-1:0]  reseed_frac;
    logic [FRAC_W-1:0]  prox_frac;
    logic [FRAC_W-1:0]  touch_frac;
    logic [FRAC_W-1:0]  release_frac;
    logic [DELAY_W-1:0] confirm_delay;
    logic [TIME_W-1:0]  prox_timeout;
    logic [TIME_W-1:0]  touch_timeout;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]   now;
    logic [SAMPLE_W-1:0] base;
    logic                seed_pending;
    mode_t               mode;
    logic                confirm_armed;
    logic [TIME_W-1:0]   confirm_start;
    logic [TIME_W-1:0]   idle_start;
    logic [TIME_W-1:0]   prox_start;
    logic [TIME_W-1:0]   touch_start;
  } state_t;

  typedef struct packed {
    mode_t               mode;
    logic [SAMPLE_W-1:0] baseline;
    logic [TIME_W-1:0]   idle_ms;
    logic [TIME_W-1:0]   proximity_ms;
    logic [TIME_W-1:0]   touch_ms;
  } result_t;

endpackage

`default_nettype wire

>>> sv/cptd_step.sv
// Combinational step of the detector: tick count, seeding, thresholds, baseline filter and mode machine.
// Depends on cptd_pkg for the configuration, state and result types.
`default_nettype none

module cptd_step (
  input  cptd_pkg::cfg_t   cfg,
  input  cptd_pkg::state_t state,
  input  logic             func,
  input  logic [cptd_pkg::SAMPLE_W-1:0] sample,
  output cptd_pkg::state_t state_next,
  output cptd_pkg::result_t result
);
  import cptd_pkg::*;

  localparam int PROD_W = SAMPLE_W + FRAC_W;

  logic [PROD_W-1:0]     p_reseed, p_prox, p_touch, p_release;
  logic [SAMPLE_W-1:0]   th_reseed;
  logic [SAMPLE_W:0]     th_prox;
  logic [SAMPLE_W+1:0]   th_touch, th_release;
  logic [SAMPLE_W+1:0]   smp_ext;
  logic signed [SAMPLE_W:0]          diff;
  logic signed [SAMPLE_W+FRAC_W+1:0] prod;
  logic signed [SAMPLE_W+1:0]        filt_step, filt_sum;
  logic [SAMPLE_W-1:0]   filtered;
  logic [TIME_W-1:0]     now;

  // Fractions of the baseline, each (f * baseline) >> 8.
  always_comb begin
    p_reseed  = PROD_W'(cfg.reseed_frac) * PROD_W'(state.base);
    p_prox    = PROD_W'(cfg.prox_frac) * PROD_W'(state.base);
    p_touch   = PROD_W'(cfg.touch_frac) * PROD_W'(state.base);
    p_release = PROD_W'(cfg.release_frac) * PROD_W'(state.base);
  end

  // Thresholds, taken from the baseline as it stood before this sample.
  always_comb begin
    th_reseed  = state.base - p_reseed[PROD_W-1:FRAC_W];
    th_prox    = {1'b0, state.base} + {1'b0, p_prox[PROD_W-1:FRAC_W]};
    th_touch   = {1'b0, th_prox} + {2'b00, p_touch[PROD_W-1:FRAC_W]};
    th_release = th_touch - {2'b00, p_release[PROD_W-1:FRAC_W]};
    smp_ext    = {2'b00, sample};
  end

  // IIR baseline filter; the arithmetic shift floors the signed step.
  always_comb begin
    diff      = $signed({1'b0, sample}) - $signed({1'b0, state.base});
    prod      = $signed({1'b0, cfg.adapt_rate}) * diff;
    filt_step = prod[SAMPLE_W+FRAC_W+1:FRAC_W];
    filt_sum  = $signed({2'b00, state.base}) + filt_step;
    filtered  = filt_sum[SAMPLE_W-1:0];
  end

  // Mode machine; idle, proximity and touch are evaluated in turn, so one
  // sample may pass through several modes.
  always_comb begin
    state_next = state;
    now = state.now;
    if (func) begin
      state_next.now = state.now + 1'b1;
    end else if (state.seed_pending) begin
      state_next.base = sample;
      state_next.seed_pending = 1'b0;
    end else begin
      if (state_next.mode == MODE_IDLE) begin
        if (smp_ext > {1'b0, th_prox}) begin
          if (!state.confirm_armed) begin
            state_next.confirm_armed = 1'b1;
            state_next.confirm_start = now;
          end else if ((now - state.confirm_start) > {16'd0, cfg.confirm_delay}) begin
            state_next.mode = MODE_PROX;
            state_next.confirm_armed = 1'b0;
            state_next.prox_start = now;
          end
        end else if (sample < th_reseed) begin
          state_next.confirm_armed = 1'b0;
          state_next.base = sample;
        end else begin
          state_next.confirm_armed = 1'b0;
          state_next.base = filtered;
        end
      end

      if (state_next.mode == MODE_PROX) begin
        if (smp_ext >= th_touch) begin
          state_next.mode = MODE_TOUCH;
          state_next.touch_start = now;
        end else if (smp_ext < {1'b0, th_prox}) begin
          state_next.mode = MODE_IDLE;
          state_next.idle_start = now;
          state_next.base = filtered;
        end else if (cfg.prox_timeout != '0 &&
                     (now - state_next.prox_start) > cfg.prox_timeout) begin
          state_next.mode = MODE_IDLE;
          state_next.idle_start = now;
          state_next.base = sample;
        end
      end

      if (state_next.mode == MODE_TOUCH) begin
        if (smp_ext < th_release) begin
          if (smp_ext >= {1'b0, th_prox}) begin
            state_next.mode = MODE_PROX;
            state_next.prox_start = now;
          end else begin
            state_next.mode = MODE_IDLE;
            state_next.idle_start = now;
            state_next.base = filtered;
          end
        end else if (cfg.touch_timeout != '0 &&
                     (now - state_next.touch_start) > cfg.touch_timeout) begin
          state_next.mode = MODE_IDLE;
          state_next.idle_start = now;
          state_next.base = sample;
        end
      end
    end
  end

  // Report after the item is applied.
  always_comb begin
    result.mode = state_next.mode;
    result.baseline = state_next.base;
    result.idle_ms = (state_next.mode == MODE_IDLE) ?
                     state_next.now - state_next.idle_start : '0;
    result.proximity_ms = (state_next.mode == MODE_PROX || state_next.mode == MODE_TOUCH) ?
                          state_next.now - state_next.prox_start : '0;
    result.touch_ms = (state_next.mode == MODE_TOUCH) ?
                      state_next.now - state_next.touch_start : '0;
  end

endmodule

`default_nettype wire

>>> sv/capacitive_proximity_touch_detector.sv
// Capacitive proximity and touch detector with a tracked baseline.
//
// Requests enter on the item channel (item_valid, item_stall, func, sample):
// func low carries an averaged sample, func high a one-millisecond tick.
// Each request yields exactly one result on the result channel (result_valid,
// result_stall, mode, baseline, idle_ms, proximity_ms, touch_ms), in order.
// A request accepted into the input register is processed by a single step of
// combinational logic, and its result is then captured in the result register,
// where it stays valid until the receiver takes it. One request is taken every
// cycle while the result side does not stall.
// When result_stall holds the output, one more request may wait in the input
// register; item_stall then rises until the result is taken.
// The configuration port (cfg_write, cfg_index, cfg_data) writes one register
// per cycle; the user must use it only while no request is in flight, as the
// block itself does not enforce it. Indexes past the last register are ignored.
// Synchronous reset empties both registers, loads the register defaults and
// returns the detector to idle with the baseline waiting for its seed sample.
// Depends on cptd_pkg and cptd_step.
`default_nettype none

module capacitive_proximity_touch_detector (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  input  logic func,
  input  logic [cptd_pkg::SAMPLE_W-1:0] sample,
  output logic result_valid,
  input  logic result_stall,
  output logic [1:0] mode,
  output logic [cptd_pkg::SAMPLE_W-1:0] baseline,
  output logic [cptd_pkg::TIME_W-1:0] idle_ms,
  output logic [cptd_pkg::TIME_W-1:0] proximity_ms,
  output logic [cptd_pkg::TIME_W-1:0] touch_ms,
  input  logic cfg_write,
  input  logic [cptd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cptd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cptd_pkg::*;

  cfg_t    cfg;
  state_t  state, state_next;
  result_t res, res_reg;
  logic    in_valid;
  logic    in_func;
  logic [SAMPLE_W-1:0] in_sample;
  logic    advance;

  // The input register moves on whenever the output register is free.
  assign advance = !result_valid || !result_stall;
  assign item_stall = in_valid && !advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adapt_rate    <= RST_ADAPT_RATE;
      cfg.reseed_frac   <= RST_RESEED_FRAC;
      cfg.prox_frac     <= RST_PROX_FRAC;
      cfg.touch_frac    <= RST_TOUCH_FRAC;
      cfg.release_frac  <= RST_RELEASE_FRAC;
      cfg.confirm_delay <= RST_CONFIRM_DELAY;
      cfg.prox_timeout  <= RST_PROX_TIMEOUT;
      cfg.touch_timeout <= RST_TOUCH_TIMEOUT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ADAPT_RATE:    cfg.adapt_rate    <= cfg_data[FRAC_W-1:0];
        REG_RESEED_FRAC:   cfg.reseed_frac   <= cfg_data[FRAC_W-1:0];
        REG_PROX_FRAC:     cfg.prox_frac     <= cfg_data[FRAC_W-1:0];
        REG_TOUCH_FRAC:    cfg.touch_frac    <= cfg_data[FRAC_W-1:0];
        REG_RELEASE_FRAC:  cfg.release_frac  <= cfg_data[FRAC_W-1:0];
        REG_CONFIRM_DELAY: cfg.confirm_delay <= cfg_data[DELAY_W-1:0];
        REG_PROX_TIMEOUT:  cfg.prox_timeout  <= cfg_data[TIME_W-1:0];
        REG_TOUCH_TIMEOUT: cfg.touch_timeout <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!item_stall) begin
      in_valid <= item_valid;
    end
    if (item_valid && !item_stall) begin
      in_func   <= func;
      in_sample <= sample;
    end
  end

  cptd_step u_step (
    .cfg        (cfg),
    .state      (state),
    .func       (in_func),
    .sample     (in_sample),
    .state_next (state_next),
    .result     (res)
  );

  // Detector state and result register; both update as a request leaves the
  // input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid        <= 1'b0;
      state.now           <= '0;
      state.base          <= '0;
      state.seed_pending  <= 1'b1;
      state.mode          <= MODE_IDLE;
      state.confirm_armed <= 1'b0;
      state.confirm_start <= '0;
      state.idle_start    <= '0;
      state.prox_start    <= '0;
      state.touch_start   <= '0;
    end else if (advance) begin
      result_valid <= in_valid;
      if (in_valid) begin
        state <= state_next;
      end
    end
    if (advance && in_valid) begin
      res_reg <= res;
    end
  end

  assign mode         = res_reg.mode;
  assign baseline     = res_reg.baseline;
  assign idle_ms      = res_reg.idle_ms;
  assign proximity_ms = res_reg.proximity_ms;
  assign touch_ms     = res_reg.touch_ms;

endmodule

`default_nettype wire

>>> sv/cptd_checker.sv
// Port-level checks for the detector, attached to the top level by bind.
// Depends on cptd_pkg and the macros in assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cptd_checker (
  input logic clk,
  input logic rst,
  input logic result_valid,
  input logic result_stall,
  input logic [1:0] mode,
  input logic [cptd_pkg::SAMPLE_W-1:0] baseline,
  input logic [cptd_pkg::TIME_W-1:0] idle_ms,
  input logic [cptd_pkg::TIME_W-1:0] proximity_ms,
  input logic [cptd_pkg::TIME_W-1:0] touch_ms
);
  import cptd_pkg::*;

  // In idle, no proximity or touch time is reported.
  `CPTD_ASSERT_IMP(a_idle_durations, clk, rst, result_valid && mode == MODE_IDLE, proximity_ms == '0 && touch_ms == '0)
  // Outside idle, the idle time reads zero.
  `CPTD_ASSERT_IMP(a_active_idle_zero, clk, rst, result_valid && (mode == MODE_PROX || mode == MODE_TOUCH), idle_ms == '0)
  // Touch time is reported only while touching.
  `CPTD_ASSERT_IMP(a_touch_only, clk, rst, result_valid && mode != MODE_TOUCH, touch_ms == '0)
  // A stalled result holds its mode and baseline.
  `CPTD_ASSERT_NEXT(a_stall_hold, clk, rst, result_valid && result_stall, result_valid && $stable(mode) && $stable(baseline))

endmodule

bind capacitive_proximity_touch_detector cptd_checker u_cptd_checker (.*);

`default_nettype wire

>>> tb/capacitive_proximity_touch_detector_test.sv
// Self-checking bench for the capacitive proximity and touch detector.
// A shadow of the baseline filter and mode machine predicts every report in order.
// Depends on cptd_pkg and the capacitive_proximity_touch_detector top level.
module capacitive_proximity_touch_detector_test;
  import cptd_pkg::*;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 4'd8;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 4'd15;
  localparam longint SAMPLE_MAX = 262143;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 300;

  // Kinds of request the stimulus can issue, mostly placed against thresholds.
  typedef enum int {
    LVL_TICK, LVL_ANY, LVL_ZERO, LVL_MAX, LVL_MID,
    LVL_UNDER_RESEED, LVL_AT_RESEED, LVL_NEAR_BASE, LVL_AT_PROX, LVL_OVER_PROX,
    LVL_AT_TOUCH, LVL_OVER_TOUCH, LVL_AT_RELEASE, LVL_UNDER_RELEASE
  } level_e;

  typedef struct packed {
    logic [TIME_W-1:0] reseed_at;
    logic [TIME_W-1:0] prox_at;
    logic [TIME_W-1:0] touch_at;
    logic [TIME_W-1:0] release_at;
  } thresholds_t;

  // Shadow of the detector: registers, tracking state and the reports still owed.
  class touch_detector_shadow;
    cfg_t                regs;
    logic [TIME_W-1:0]   now_ms;
    logic [SAMPLE_W-1:0] base;
    logic                seed_pending;
    mode_t               det_mode;
    logic                armed;
    logic [TIME_W-1:0]   confirm_start;
    logic [TIME_W-1:0]   idle_start;
    logic [TIME_W-1:0]   prox_start;
    logic [TIME_W-1:0]   touch_start;
    result_t             pending_reports[$];
    int                  mismatches;

    function new();
      regs.adapt_rate    = RST_ADAPT_RATE;
      regs.reseed_frac   = RST_RESEED_FRAC;
      regs.prox_frac     = RST_PROX_FRAC;
      regs.touch_frac    = RST_TOUCH_FRAC;
      regs.release_frac  = RST_RELEASE_FRAC;
      regs.confirm_delay = RST_CONFIRM_DELAY;
      regs.prox_timeout  = RST_PROX_TIMEOUT;
      regs.touch_timeout = RST_TOUCH_TIMEOUT;
      now_ms = '0;
      base = '0;
      seed_pending = 1'b1;
      det_mode = MODE_IDLE;
      armed = 1'b0;
      confirm_start = '0;
      idle_start = '0;
      prox_start = '0;
      touch_start = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ADAPT_RATE:    regs.adapt_rate = data[FRAC_W-1:0];
        REG_RESEED_FRAC:   regs.reseed_frac = data[FRAC_W-1:0];
        REG_PROX_FRAC:     regs.prox_frac = data[FRAC_W-1:0];
        REG_TOUCH_FRAC:    regs.touch_frac = data[FRAC_W-1:0];
        REG_RELEASE_FRAC:  regs.release_frac = data[FRAC_W-1:0];
        REG_CONFIRM_DELAY: regs.confirm_delay = data[DELAY_W-1:0];
        REG_PROX_TIMEOUT:  regs.prox_timeout = data;
        REG_TOUCH_TIMEOUT: regs.touch_timeout = data;
        default: ;
      endcase
    endfunction

    // Fraction f/256 of the current baseline.
    function logic [TIME_W-1:0] share(logic [FRAC_W-1:0] f);
      return (32'(f) * 32'(base)) >> 8;
    endfunction

    function thresholds_t limits();
      thresholds_t t;
      t.reseed_at  = base - share(regs.reseed_frac);
      t.prox_at    = base + share(regs.prox_frac);
      t.touch_at   = t.prox_at + share(regs.touch_frac);
      t.release_at = t.touch_at - share(regs.release_frac);
      return t;
    endfunction

    // IIR step toward the sample with a flooring shift.
    function void track(logic [SAMPLE_W-1:0] smp);
      longint diff;
      longint prod;
      longint sum;
      diff = longint'(smp) - longint'(base);
      prod = longint'(regs.adapt_rate) * diff;
      sum = longint'(base) + (prod >>> 8);
      base = sum[SAMPLE_W-1:0];
    endfunction

    // Apply one accepted request and queue the report it owes.
    function void take_request(logic f, logic [SAMPLE_W-1:0] smp);
      thresholds_t t;
      result_t r;
      if (f == FUNC_TICK) begin
        now_ms = now_ms + 1;
      end else if (seed_pending) begin
        base = smp;
        seed_pending = 1'b0;
      end else begin
        t = limits();
        // Idle: confirm a rise, reseed on a deep drop, otherwise track.
        if (det_mode == MODE_IDLE) begin
          if (smp > t.prox_at) begin
            if (!armed) begin
              armed = 1'b1;
              confirm_start = now_ms;
            end else if (now_ms - confirm_start > 32'(regs.confirm_delay)) begin
              det_mode = MODE_PROX;
              armed = 1'b0;
              prox_start = now_ms;
            end
          end else if (smp < t.reseed_at) begin
            armed = 1'b0;
            base = smp;
          end else begin
            armed = 1'b0;
            track(smp);
          end
        end
        // Proximity: escalate, fall back, or time out.
        if (det_mode == MODE_PROX) begin
          if (smp >= t.touch_at) begin
            det_mode = MODE_TOUCH;
            touch_start = now_ms;
          end else if (smp < t.prox_at) begin
            det_mode = MODE_IDLE;
            idle_start = now_ms;
            track(smp);
          end else if (regs.prox_timeout != 0 && now_ms - prox_start > regs.prox_timeout) begin
            det_mode = MODE_IDLE;
            idle_start = now_ms;
            base = smp;
          end
        end
        // Touch: release with hysteresis, or time out.
        if (det_mode == MODE_TOUCH) begin
          if (smp < t.release_at) begin
            if (smp >= t.prox_at) begin
              det_mode = MODE_PROX;
              prox_start = now_ms;
            end else begin
              det_mode = MODE_IDLE;
              idle_start = now_ms;
              track(smp);
            end
          end else if (regs.touch_timeout != 0 &&
                       now_ms - touch_start > regs.touch_timeout) begin
            det_mode = MODE_IDLE;
            idle_start = now_ms;
            base = smp;
          end
        end
      end
      r.mode = det_mode;
      r.baseline = base;
      r.idle_ms = (det_mode == MODE_IDLE) ? now_ms - idle_start : '0;
      r.proximity_ms = (det_mode != MODE_IDLE) ? now_ms - prox_start : '0;
      r.touch_ms = (det_mode == MODE_TOUCH) ? now_ms - touch_start : '0;
      pending_reports.push_back(r);
    endfunction

    function void field_check(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(result_t got);
      result_t want;
      if (pending_reports.size() == 0) begin
        $error("report with no request outstanding");
        mismatches++;
        return;
      end
      want = pending_reports.pop_front();
      field_check("mode", 32'(want.mode), 32'(got.mode));
      field_check("baseline", 32'(want.baseline), 32'(got.baseline));
      field_check("idle_ms", want.idle_ms, got.idle_ms);
      field_check("proximity_ms", want.proximity_ms, got.proximity_ms);
      field_check("touch_ms", want.touch_ms, got.touch_ms);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  logic func;
  logic [SAMPLE_W-1:0] sample;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [1:0] mode;
  logic [SAMPLE_W-1:0] baseline;
  logic [TIME_W-1:0] idle_ms;
  logic [TIME_W-1:0] proximity_ms;
  logic [TIME_W-1:0] touch_ms;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  touch_detector_shadow shadow;
  int unsigned sender_idle;
  int unsigned receiver_stall;
  int unsigned cycles;
  int ticks_left;
  level_e opening_run[$];
  int unsigned idle_plan[4] = '{0, 73, 0, 33};
  int unsigned stall_plan[4] = '{0, 0, 73, 33};

  capacitive_proximity_touch_detector i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .func(func),
    .sample(sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .mode(mode),
    .baseline(baseline),
    .idle_ms(idle_ms),
    .proximity_ms(proximity_ms),
    .touch_ms(touch_ms),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side stalls at random on the falling edge.
  always @(negedge clk) begin
    result_stall = ($urandom_range(99) < receiver_stall);
  end

  // Watch both handshakes on the rising edge.
  always @(posedge clk) begin : watch
    result_t seen;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        shadow.take_request(func, sample);
      end
      if (result_valid && !result_stall) begin
        seen.mode = mode_t'(mode);
        seen.baseline = baseline;
        seen.idle_ms = idle_ms;
        seen.proximity_ms = proximity_ms;
        seen.touch_ms = touch_ms;
        shadow.check_report(seen);
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sample value for a request kind, placed against the current thresholds.
  function automatic logic [SAMPLE_W-1:0] level_value(level_e k);
    thresholds_t t;
    longint v;
    t = shadow.limits();
    case (k)
      LVL_ZERO:          v = 0;
      LVL_MAX:           v = SAMPLE_MAX;
      LVL_MID:           v = 40000 + longint'($urandom_range(0, 1000));
      LVL_UNDER_RESEED:  v = longint'(t.reseed_at) - 1 - longint'($urandom_range(0, 3));
      LVL_AT_RESEED:     v = longint'(t.reseed_at);
      LVL_NEAR_BASE:     v = longint'($urandom_range(t.reseed_at, t.prox_at));
      LVL_AT_PROX:       v = longint'(t.prox_at);
      LVL_OVER_PROX: begin
        if (t.touch_at > t.prox_at + 1) begin
          v = longint'($urandom_range(t.prox_at + 1, t.touch_at - 1));
        end else begin
          v = longint'(t.prox_at) + 1;
        end
      end
      LVL_AT_TOUCH:      v = longint'(t.touch_at);
      LVL_OVER_TOUCH:    v = longint'(t.touch_at) + longint'($urandom_range(0, 50));
      LVL_AT_RELEASE:    v = longint'(t.release_at);
      LVL_UNDER_RELEASE: v = longint'(t.release_at) - 1 - longint'($urandom_range(0, 3));
      default:           v = longint'($urandom_range(0, 262143));
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v[SAMPLE_W-1:0];
  endfunction

  // Random request kind: bursts of ticks, some noise, and levels that drive
  // the machine forward or back from the mode it is in.
  function automatic level_e next_level();
    int unsigned r;
    if (ticks_left > 0) begin
      ticks_left--;
      return LVL_TICK;
    end
    r = $urandom_range(99);
    if (r < 30) begin
      ticks_left = ($urandom_range(9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
      return LVL_TICK;
    end
    if (r < 34) return LVL_ANY;
    if (r < 36) return LVL_ZERO;
    if (r < 38) return LVL_MAX;
    r = $urandom_range(99);
    case (shadow.det_mode)
      MODE_IDLE: begin
        if (r < 50) return LVL_OVER_PROX;
        if (r < 70) return LVL_NEAR_BASE;
        if (r < 80) return LVL_AT_PROX;
        if (r < 88) return LVL_UNDER_RESEED;
        if (r < 94) return LVL_AT_RESEED;
        return LVL_OVER_TOUCH;
      end
      MODE_PROX: begin
        if (r < 35) return LVL_OVER_TOUCH;
        if (r < 45) return LVL_AT_TOUCH;
        if (r < 70) return LVL_OVER_PROX;
        if (r < 80) return LVL_AT_PROX;
        return LVL_NEAR_BASE;
      end
      default: begin
        if (r < 35) return LVL_OVER_TOUCH;
        if (r < 50) return LVL_AT_RELEASE;
        if (r < 75) return LVL_UNDER_RELEASE;
        return LVL_NEAR_BASE;
      end
    endcase
  endfunction

  // Present one request after a random gap and hold it until accepted.
  task automatic send_item(level_e k);
    while ($urandom_range(99) < sender_idle) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    if (k == LVL_TICK) begin
      func = FUNC_TICK;
      sample = level_value(LVL_ANY);
    end else begin
      func = FUNC_SAMPLE;
      sample = level_value(k);
    end
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    shadow.write_reg(idx, data);
  endtask

  task automatic load_settings(logic [31:0] rate, logic [31:0] reseed, logic [31:0] prox,
                               logic [31:0] touch, logic [31:0] rel, logic [31:0] delay,
                               logic [31:0] prox_to, logic [31:0] touch_to);
    write_register(REG_ADAPT_RATE, rate);
    write_register(REG_RESEED_FRAC, reseed);
    write_register(REG_PROX_FRAC, prox);
    write_register(REG_TOUCH_FRAC, touch);
    write_register(REG_RELEASE_FRAC, rel);
    write_register(REG_CONFIRM_DELAY, delay);
    write_register(REG_PROX_TIMEOUT, prox_to);
    write_register(REG_TOUCH_TIMEOUT, touch_to);
  endtask

  // Stop requests and wait until every report is back and the pipe is quiet.
  task automatic settle();
    item_valid = 1'b0;
    while (shadow.pending_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    bit quiet;
    int unsigned phase_idle;
    int unsigned phase_stall;
    clk = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    func = FUNC_SAMPLE;
    sample = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    ticks_left = 0;
    sender_idle = 0;
    receiver_stall = 0;
    shadow = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed walk: seeding, confirm, cascade to touch, release to proximity,
    // both timeouts, reseed, sample extremes and writes to unused indexes.
    load_settings(128, 32, 32, 32, 8, 1, 2, 2);
    write_register(REG_SPARE_LO, $urandom());
    write_register(REG_SPARE_HI, $urandom());
    opening_run = '{LVL_MID, LVL_TICK, LVL_NEAR_BASE, LVL_AT_PROX, LVL_OVER_PROX,
                    LVL_TICK, LVL_TICK, LVL_OVER_TOUCH, LVL_AT_RELEASE, LVL_UNDER_RELEASE,
                    LVL_TICK, LVL_TICK, LVL_TICK, LVL_AT_PROX, LVL_UNDER_RESEED,
                    LVL_ZERO, LVL_MAX, LVL_TICK, LVL_TICK, LVL_MAX,
                    LVL_TICK, LVL_TICK, LVL_TICK, LVL_MAX, LVL_NEAR_BASE};
    foreach (opening_run[i]) send_item(opening_run[i]);
    settle();

    // Random phases, each under its own register setting; the idling patterns repeat every four phases.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_settings(4, 32, 32, 32, 8, 0, 0, 0);
        1: load_settings(255, 255, 255, 255, 255, 3, 4, 4);
        2: load_settings(0, 0, 0, 0, 0, 0, 1, 1);
        3: load_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom_range(1, 4), $urandom_range(2, 12), $urandom_range(2, 12));
        4: load_settings($urandom_range(1, 64), $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255), 32'hFFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: load_settings(RST_ADAPT_RATE, RST_RESEED_FRAC, RST_PROX_FRAC, RST_TOUCH_FRAC,
                               RST_RELEASE_FRAC, RST_CONFIRM_DELAY, RST_PROX_TIMEOUT,
                               RST_TOUCH_TIMEOUT);
      endcase
      phase_idle = idle_plan[phase % 4];
      phase_stall = stall_plan[phase % 4];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Now and then a stretch runs with no idling at all.
        if (n % 40 == 0) begin
          quiet = ($urandom_range(3) == 0);
          sender_idle = quiet ? 0 : phase_idle;
          receiver_stall = quiet ? 0 : phase_stall;
        end
        send_item(next_level());
      end
      sender_idle = 0;
      receiver_stall = 0;
      settle();
    end

    if (shadow.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+sv
sv/cptd_pkg.sv
sv/cptd_step.sv
sv/capacitive_proximity_touch_detector.sv
sv/cptd_checker.sv
tb/capacitive_proximity_touch_detector_test.sv
